// ===== design/ifs_pkg.sv =====
// shared constants, preset rom and fixed-point table builders for the ifs point generator
// no dependencies; used by ifs_affine, ifs_scale and the top level
package ifs_pkg;

  localparam int PT_W        = 24;  // stored point coordinate, signed
  localparam int DIG_W       = 4;   // digit width of the serial multipliers
  localparam int PT_DIGITS   = PT_W / DIG_W;
  localparam int SIZE_W      = 13;  // screen size register width
  localparam int SIZE_DIGITS = 4;   // size - 1 padded to SIZE_DIGITS * DIG_W bits
  localparam int PIX_W       = 12;
  localparam int PCT_W       = 7;
  localparam int PRESET_W    = 3;
  localparam int NUM_PRESETS = 6;
  localparam int MAX_MAPS    = 5;
  localparam int SEL_W       = 3;
  localparam int NUM_COEFS   = 6;
  localparam int TAB_W       = 32;
  localparam longint DEC_SCALE = 10000000;

  // coefficient order inside one map
  localparam int COEF_A = 0;
  localparam int COEF_B = 1;
  localparam int COEF_C = 2;
  localparam int COEF_D = 3;
  localparam int COEF_E = 4;
  localparam int COEF_F = 5;

  // derived bounding box entries
  localparam int BOX_XMIN  = 0;
  localparam int BOX_YMAX  = 1;
  localparam int BOX_XSPAN = 2;
  localparam int BOX_YSPAN = 3;

  localparam logic [PT_W-1:0] PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
  localparam logic [PT_W-1:0] PT_MIN = {1'b1, {(PT_W-1){1'b0}}};

  typedef logic [NUM_PRESETS-1:0][MAX_MAPS-1:0][NUM_COEFS-1:0][TAB_W-1:0] map_tab_t;
  typedef logic [NUM_PRESETS-1:0][3:0][TAB_W-1:0] box_tab_t;

  localparam logic [SEL_W-1:0] MAP_COUNT [NUM_PRESETS] = '{
    3'd3, 3'd4, 3'd4, 3'd3, 3'd5, 3'd5
  };

  localparam logic [PCT_W-1:0] MAP_THR [NUM_PRESETS][MAX_MAPS] = '{
    '{7'd33, 7'd66, 7'd100, 7'd100, 7'd100},
    '{7'd1,  7'd8,  7'd15,  7'd100, 7'd100},
    '{7'd5,  7'd20, 7'd60,  7'd100, 7'd100},
    '{7'd33, 7'd66, 7'd100, 7'd100, 7'd100},
    '{7'd96, 7'd97, 7'd98,  7'd99,  7'd100},
    '{7'd18, 7'd56, 7'd74,  7'd94,  7'd100}
  };

  // xmin, ymin, xmax, ymax in units of 1e-7
  localparam int BOX_DEC [NUM_PRESETS][4] = '{
    '{0, 0, 20000000, 10000000},
    '{-21816700, 746271, 26556800, 99981800},
    '{-2500000, 0, 2500000, 5000000},
    '{0, 0, 20000000, 20000000},
    '{0, 0, 10000000, 10000000},
    '{0, 0, 10000000, 10000000}
  };

  // a, b, c, d, e, f in units of 1e-7
  localparam int MAP_DEC [NUM_PRESETS][MAX_MAPS][NUM_COEFS] = '{
    '{ '{5000000, 0, 0, 5000000, 0, 0},
       '{5000000, 0, 0, 5000000, 10000000, 0},
       '{5000000, 0, 0, 5000000, 5000000, 5000000},
       '{0, 0, 0, 0, 0, 0},
       '{0, 0, 0, 0, 0, 0} },
    '{ '{0, 0, 0, 1600000, 0, 0},
       '{2000000, -2600000, 2300000, 2200000, 0, 16000000},
       '{-1500000, 2800000, 2600000, 2400000, 0, 4400000},
       '{8500000, 400000, -400000, 8500000, 0, 16000000},
       '{0, 0, 0, 0, 0, 0} },
    '{ '{0, 0, 0, 5000000, 0, 0},
       '{1000000, 0, 0, 1000000, 0, 2000000},
       '{4200000, -4200000, 4200000, 4200000, 0, 2000000},
       '{4200000, 4200000, -4200000, 4200000, 0, 2000000},
       '{0, 0, 0, 0, 0, 0} },
    '{ '{3330000, 0, 0, 3330000, 0, 0},
       '{3330000, 0, 0, 3330000, 10000000, 0},
       '{6670000, 0, 0, 6670000, 5000000, 5000000},
       '{0, 0, 0, 0, 0, 0},
       '{0, 0, 0, 0, 0, 0} },
    '{ '{1559600, 9877600, -9877600, 1559600, -779000, 9124000},
       '{442800, 0, 0, 411600, 641000, 4829000},
       '{556600, 0, 0, 452700, 998000, 4779000},
       '{1154000, 0, 0, 509400, 1428000, 4761000},
       '{2714200, 0, 0, 493200, 2380000, 4781000} },
    '{ '{3517300, 3553700, -3553700, 3517300, 3534000, 5000000},
       '{3533800, -3537000, 3537300, 3533800, 2879000, 1528000},
       '{5000000, 0, 0, 5000000, 2500000, 4620000},
       '{5015400, -18000, 15700, 5879500, 2501000, 1054000},
       '{36400, 0, 0, 5783200, 5016000, 606000} }
  };

  // decimal to fixed point, rounding half away from zero
  function automatic longint to_fixed(input longint dec, input int frac);
    longint mag;
    longint res;
    mag = (dec < 0) ? -dec : dec;
    res = ((mag <<< frac) + DEC_SCALE / 2) / DEC_SCALE;
    return (dec < 0) ? -res : res;
  endfunction

  function automatic map_tab_t fixed_maps(input int frac);
    map_tab_t tab;
    tab = '0;
    for (int p = 0; p < NUM_PRESETS; p++) begin
      for (int m = 0; m < MAX_MAPS; m++) begin
        for (int k = 0; k < NUM_COEFS; k++) begin
          tab[p][m][k] = TAB_W'(to_fixed(longint'(MAP_DEC[p][m][k]), frac));
        end
      end
    end
    return tab;
  endfunction

  function automatic box_tab_t fixed_boxes(input int frac);
    box_tab_t tab;
    longint   xmin;
    longint   ymin;
    longint   xmax;
    longint   ymax;
    tab = '0;
    for (int p = 0; p < NUM_PRESETS; p++) begin
      xmin = to_fixed(longint'(BOX_DEC[p][0]), frac);
      ymin = to_fixed(longint'(BOX_DEC[p][1]), frac);
      xmax = to_fixed(longint'(BOX_DEC[p][2]), frac);
      ymax = to_fixed(longint'(BOX_DEC[p][3]), frac);
      tab[p][BOX_XMIN]  = TAB_W'(xmin);
      tab[p][BOX_YMAX]  = TAB_W'(ymax);
      tab[p][BOX_XSPAN] = TAB_W'(xmax - xmin);
      tab[p][BOX_YSPAN] = TAB_W'(ymax - ymin);
    end
    return tab;
  endfunction

endpackage

// ===== design/ifs_affine.sv =====
// digit-serial affine map unit: holds the point and applies x' = a*x+b*y+e, y' = c*x+d*y+f
// depends on ifs_pkg
module ifs_affine #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            clear_i,
  input  logic                                            start_i,
  input  logic [ifs_pkg::NUM_COEFS-1:0][FRAC_BITS+4:0]    coef_i,
  output logic                                            done_o,
  output logic signed [ifs_pkg::PT_W-1:0]                 point_x_o,
  output logic signed [ifs_pkg::PT_W-1:0]                 point_y_o
);

  localparam int COEF_W = FRAC_BITS + 5;
  localparam int ACC_W  = COEF_W + ifs_pkg::PT_W + 2;
  localparam int PROD_W = COEF_W + ifs_pkg::DIG_W + 1;
  localparam int CNT_W  = $clog2(ifs_pkg::PT_DIGITS + 1);
  localparam int RND_W  = COEF_W + FRAC_BITS;

  typedef enum logic [2:0] {
    MS_IDLE  = 3'b001,
    MS_ACC   = 3'b010,
    MS_ROUND = 3'b100
  } map_state_e;

  map_state_e                                   state_q, state_d;
  logic [CNT_W-1:0]                             cnt_q, cnt_d;
  logic [ifs_pkg::PT_W-1:0]                     x_sr_q, x_sr_d, y_sr_q, y_sr_d;
  logic [ifs_pkg::NUM_COEFS-1:0][COEF_W-1:0]    coef_q, coef_d;
  logic signed [ACC_W-1:0]                      acc_x_q, acc_x_d, acc_y_q, acc_y_d;
  logic signed [ifs_pkg::PT_W-1:0]              px_q, px_d, py_q, py_d;
  logic                                         done_q, done_d;

  logic                                         first;
  logic signed [ifs_pkg::DIG_W:0]               xd, yd;
  logic signed [PROD_W-1:0]                     prod_ax, prod_bx, prod_cy, prod_dy;
  logic signed [RND_W-1:0]                      k_x, k_y;
  logic signed [ACC_W:0]                        t_x, t_y, sh_x, sh_y;
  logic signed [ifs_pkg::PT_W-1:0]              nx, ny;

  // saturate a rounded coordinate to the point width
  function automatic logic [ifs_pkg::PT_W-1:0] sat_pt(input logic signed [ACC_W:0] v);
    logic fits;
    fits = (&v[ACC_W:ifs_pkg::PT_W-1]) | ~(|v[ACC_W:ifs_pkg::PT_W-1]);
    if (fits) begin
      return v[ifs_pkg::PT_W-1:0];
    end else if (v[ACC_W]) begin
      return ifs_pkg::PT_MIN;
    end else begin
      return ifs_pkg::PT_MAX;
    end
  endfunction

  // most significant digit first; the top digit carries the sign
  assign first = (cnt_q == CNT_W'(ifs_pkg::PT_DIGITS));
  assign xd = {first & x_sr_q[ifs_pkg::PT_W-1],
               x_sr_q[ifs_pkg::PT_W-1 -: ifs_pkg::DIG_W]};
  assign yd = {first & y_sr_q[ifs_pkg::PT_W-1],
               y_sr_q[ifs_pkg::PT_W-1 -: ifs_pkg::DIG_W]};

  assign prod_ax = $signed(coef_q[ifs_pkg::COEF_A]) * xd;
  assign prod_bx = $signed(coef_q[ifs_pkg::COEF_B]) * yd;
  assign prod_cy = $signed(coef_q[ifs_pkg::COEF_C]) * xd;
  assign prod_dy = $signed(coef_q[ifs_pkg::COEF_D]) * yd;

  // offset shifted up plus the rounding half, no adder needed
  assign k_x = {coef_q[ifs_pkg::COEF_E], 1'b1, {(FRAC_BITS-1){1'b0}}};
  assign k_y = {coef_q[ifs_pkg::COEF_F], 1'b1, {(FRAC_BITS-1){1'b0}}};

  assign t_x  = (ACC_W+1)'(acc_x_q) + (ACC_W+1)'(k_x);
  assign t_y  = (ACC_W+1)'(acc_y_q) + (ACC_W+1)'(k_y);
  assign sh_x = t_x >>> FRAC_BITS;
  assign sh_y = t_y >>> FRAC_BITS;
  assign nx   = sat_pt(sh_x);
  assign ny   = sat_pt(sh_y);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    x_sr_d  = x_sr_q;
    y_sr_d  = y_sr_q;
    coef_d  = coef_q;
    acc_x_d = acc_x_q;
    acc_y_d = acc_y_q;
    px_d    = px_q;
    py_d    = py_q;
    done_d  = 1'b0;
    case (state_q)
      MS_IDLE: begin
        if (start_i) begin
          x_sr_d  = px_q;
          y_sr_d  = py_q;
          coef_d  = coef_i;
          acc_x_d = '0;
          acc_y_d = '0;
          cnt_d   = CNT_W'(ifs_pkg::PT_DIGITS);
          state_d = MS_ACC;
        end
      end
      MS_ACC: begin
        acc_x_d = (acc_x_q <<< ifs_pkg::DIG_W) + ACC_W'(prod_ax) + ACC_W'(prod_bx);
        acc_y_d = (acc_y_q <<< ifs_pkg::DIG_W) + ACC_W'(prod_cy) + ACC_W'(prod_dy);
        x_sr_d  = x_sr_q << ifs_pkg::DIG_W;
        y_sr_d  = y_sr_q << ifs_pkg::DIG_W;
        cnt_d   = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = MS_ROUND;
        end
      end
      MS_ROUND: begin
        px_d    = nx;
        py_d    = ny;
        done_d  = 1'b1;
        state_d = MS_IDLE;
      end
      default: begin
        state_d = MS_IDLE;
      end
    endcase
    if (clear_i) begin
      px_d = '0;
      py_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MS_IDLE;
      cnt_q   <= '0;
      px_q    <= '0;
      py_q    <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      px_q    <= px_d;
      py_q    <= py_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_sr_q  <= x_sr_d;
    y_sr_q  <= y_sr_d;
    coef_q  <= coef_d;
    acc_x_q <= acc_x_d;
    acc_y_q <= acc_y_d;
  end

  assign done_o    = done_q;
  assign point_x_o = px_q;
  assign point_y_o = py_q;

endmodule

// ===== design/ifs_scale.sv =====
// one screen axis: digit-serial (size-1)*offset, then bit-serial division by the box span
// and clamping to the screen; depends on ifs_pkg
module ifs_scale #(
  parameter int OFF_W  = 25,
  parameter int SPAN_W = 20
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [OFF_W-1:0]             offset_i,
  input  logic [SPAN_W-1:0]                   span_i,
  input  logic [ifs_pkg::SIZE_W-1:0]          size_i,
  output logic                                done_o,
  output logic [ifs_pkg::PIX_W-1:0]           pixel_o,
  output logic                                in_range_o
);

  localparam int MUL_W  = ifs_pkg::SIZE_DIGITS * ifs_pkg::DIG_W;
  localparam int NUM_W  = OFF_W + MUL_W + 1;
  localparam int PROD_W = OFF_W + ifs_pkg::DIG_W + 1;
  localparam int DIV_W  = SPAN_W + ifs_pkg::PIX_W;
  localparam int QUO_W  = ifs_pkg::PIX_W + 1;
  localparam int CNT_W  = $clog2(QUO_W + 1);

  typedef enum logic [3:0] {
    SS_IDLE = 4'b0001,
    SS_MUL  = 4'b0010,
    SS_DIV  = 4'b0100,
    SS_DONE = 4'b1000
  } scale_state_e;

  scale_state_e                    state_q, state_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic signed [OFF_W-1:0]         off_q, off_d;
  logic [MUL_W-1:0]                mul_sr_q, mul_sr_d;
  logic signed [NUM_W-1:0]         acc_q, acc_d;
  logic [DIV_W-1:0]                div_q, div_d;
  logic [QUO_W-1:0]                quo_q, quo_d;
  logic [ifs_pkg::PIX_W-1:0]       lim_q, lim_d;
  logic [ifs_pkg::PIX_W-1:0]       pixel_q, pixel_d;
  logic                            ok_q, ok_d;
  logic                            done_q, done_d;

  logic [ifs_pkg::SIZE_W-1:0]      size_m1;
  logic signed [PROD_W-1:0]        prod;
  logic signed [NUM_W-1:0]         div_ext;
  logic                            ge;

  // a size of zero counts as one
  assign size_m1 = (size_i == '0) ? '0 : size_i - ifs_pkg::SIZE_W'(1);

  assign prod    = off_q * $signed({1'b0, mul_sr_q[MUL_W-1 -: ifs_pkg::DIG_W]});
  assign div_ext = $signed({{(NUM_W-DIV_W){1'b0}}, div_q});
  // negative numerator never subtracts, so its sign survives the division
  assign ge      = (acc_q >= div_ext);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    off_d    = off_q;
    mul_sr_d = mul_sr_q;
    acc_d    = acc_q;
    div_d    = div_q;
    quo_d    = quo_q;
    lim_d    = lim_q;
    pixel_d  = pixel_q;
    ok_d     = ok_q;
    done_d   = 1'b0;
    case (state_q)
      SS_IDLE: begin
        if (start_i) begin
          off_d    = offset_i;
          mul_sr_d = MUL_W'(size_m1);
          lim_d    = (|size_m1[ifs_pkg::SIZE_W-1:ifs_pkg::PIX_W]) ? '1
                                                                  : size_m1[ifs_pkg::PIX_W-1:0];
          div_d    = {span_i, {ifs_pkg::PIX_W{1'b0}}};
          acc_d    = '0;
          quo_d    = '0;
          cnt_d    = CNT_W'(ifs_pkg::SIZE_DIGITS);
          state_d  = SS_MUL;
        end
      end
      SS_MUL: begin
        acc_d    = (acc_q <<< ifs_pkg::DIG_W) + NUM_W'(prod);
        mul_sr_d = mul_sr_q << ifs_pkg::DIG_W;
        cnt_d    = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          cnt_d   = CNT_W'(QUO_W);
          state_d = SS_DIV;
        end
      end
      SS_DIV: begin
        // restoring division, one quotient bit per cycle
        if (ge) begin
          acc_d = acc_q - div_ext;
        end
        quo_d = {quo_q[QUO_W-2:0], ge};
        div_d = div_q >> 1;
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          state_d = SS_DONE;
        end
      end
      SS_DONE: begin
        if (acc_q[NUM_W-1]) begin
          pixel_d = '0;
          ok_d    = 1'b0;
        end else if (quo_q[QUO_W-1] || (quo_q[ifs_pkg::PIX_W-1:0] > lim_q)) begin
          pixel_d = lim_q;
          ok_d    = 1'b0;
        end else begin
          pixel_d = quo_q[ifs_pkg::PIX_W-1:0];
          ok_d    = 1'b1;
        end
        done_d  = 1'b1;
        state_d = SS_IDLE;
      end
      default: begin
        state_d = SS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SS_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q    <= off_d;
    mul_sr_q <= mul_sr_d;
    acc_q    <= acc_d;
    div_q    <= div_d;
    quo_q    <= quo_d;
    lim_q    <= lim_d;
    pixel_q  <= pixel_d;
    ok_q     <= ok_d;
  end

  assign done_o     = done_q;
  assign pixel_o    = pixel_q;
  assign in_range_o = ok_q;

endmodule

// ===== design/ifs_chaos_game_point_generator.sv =====
// top level of the chaos-game point generator: config registers, map selection, sequencing
// and output register; depends on ifs_pkg, ifs_affine and ifs_scale
//
// sequence: the input transfer starts the map unit, then both scale units, then the output register
// a new item is taken only once the last one has been loaded into the output register, after the
//   6-digit serial affine multiply and the 4-digit size multiply plus 13-step bit-serial division
// reset: rst_ni (async, active low) sets preset 1, 640 x 480 screen and the point to (0,0)
module ifs_chaos_game_point_generator #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] percent
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [11:0] pixel_x, [23:12] pixel_y
  output logic        m_axis_tuser,   // [0] in_view
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,    // 0 preset, 1 screen_width, 2 screen_height
  input  logic [12:0] cfg_data_i
);

  localparam int COEF_W = FRAC_BITS + 5;
  localparam int SPAN_W = FRAC_BITS + 4;
  localparam int OFF_W  = ((FRAC_BITS + 5 > ifs_pkg::PT_W) ? FRAC_BITS + 5
                                                            : ifs_pkg::PT_W) + 1;

  // register indexes on the config port
  localparam logic [1:0] REG_PRESET = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // preset rom converted to fixed point at elaboration
  localparam ifs_pkg::map_tab_t MAP_FIX = ifs_pkg::fixed_maps(FRAC_BITS);
  localparam ifs_pkg::box_tab_t BOX_FIX = ifs_pkg::fixed_boxes(FRAC_BITS);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MAP   = 4'b0010,
    ST_SCALE = 4'b0100,
    ST_OUT   = 4'b1000
  } top_state_e;

  top_state_e                                  state_q, state_d;
  logic [ifs_pkg::PRESET_W-1:0]                preset_q, preset_d;
  logic [ifs_pkg::SIZE_W-1:0]                  width_q, width_d;
  logic [ifs_pkg::SIZE_W-1:0]                  height_q, height_d;

  // output register, parts the result side from the working logic
  logic                                        m_valid_q, m_valid_d;
  logic [ifs_pkg::PIX_W-1:0]                   pix_x_q, pix_x_d, pix_y_q, pix_y_d;
  logic                                        in_view_q, in_view_d;

  logic                                        in_xfer;
  logic                                        cfg_xfer;
  logic                                        clear_point;
  logic                                        preset_ok;
  logic [ifs_pkg::PRESET_W-1:0]                pidx;
  logic [ifs_pkg::PCT_W-1:0]                   percent;
  logic [ifs_pkg::SEL_W-1:0]                   sel;
  logic                                        found;
  logic [ifs_pkg::NUM_COEFS-1:0][COEF_W-1:0]   coef;
  logic                                        map_start;
  logic                                        map_done;
  logic signed [ifs_pkg::PT_W-1:0]             point_x, point_y;
  logic signed [COEF_W-1:0]                    xmin, ymax;
  logic [SPAN_W-1:0]                           span_x, span_y;
  logic signed [OFF_W-1:0]                     off_x, off_y;
  logic                                        scale_start;
  logic                                        done_x, done_y, scale_done;
  logic [ifs_pkg::PIX_W-1:0]                   scaled_x, scaled_y;
  logic                                        ok_x, ok_y;
  logic                                        out_free;
  logic                                        load_out;

  // writes are always taken; the user must write only while idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign percent       = s_axis_tdata[ifs_pkg::PCT_W-1:0];

  // presets 6 and 7 drop the item without a result
  assign preset_ok = (preset_q < ifs_pkg::PRESET_W'(ifs_pkg::NUM_PRESETS));
  assign pidx      = preset_ok ? preset_q : '0;
  assign map_start = in_xfer & preset_ok;

  // first map whose cumulative threshold lies above the percentage, else the last one
  always_comb begin
    sel   = ifs_pkg::MAP_COUNT[pidx] - ifs_pkg::SEL_W'(1);
    found = 1'b0;
    for (int j = 0; j < ifs_pkg::MAX_MAPS; j++) begin
      if (!found && (ifs_pkg::SEL_W'(j) < ifs_pkg::MAP_COUNT[pidx]) &&
          (percent < ifs_pkg::MAP_THR[pidx][j])) begin
        sel   = ifs_pkg::SEL_W'(j);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < ifs_pkg::NUM_COEFS; k++) begin
      coef[k] = MAP_FIX[pidx][sel][k][COEF_W-1:0];
    end
  end

  // a preset write restarts the drawing from the origin
  assign clear_point = cfg_xfer && (cfg_index_i == REG_PRESET);

  ifs_affine #(
    .FRAC_BITS (FRAC_BITS)
  ) u_affine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (clear_point),
    .start_i   (map_start),
    .coef_i    (coef),
    .done_o    (map_done),
    .point_x_o (point_x),
    .point_y_o (point_y)
  );

  // bounding box of the active preset; row 0 of the screen is ymax
  assign xmin   = $signed(BOX_FIX[pidx][ifs_pkg::BOX_XMIN][COEF_W-1:0]);
  assign ymax   = $signed(BOX_FIX[pidx][ifs_pkg::BOX_YMAX][COEF_W-1:0]);
  assign span_x = BOX_FIX[pidx][ifs_pkg::BOX_XSPAN][SPAN_W-1:0];
  assign span_y = BOX_FIX[pidx][ifs_pkg::BOX_YSPAN][SPAN_W-1:0];
  assign off_x  = OFF_W'(point_x) - OFF_W'(xmin);
  assign off_y  = OFF_W'(ymax) - OFF_W'(point_y);

  // the new point is valid in the cycle the map unit reports done
  assign scale_start = map_done;

  ifs_scale #(
    .OFF_W  (OFF_W),
    .SPAN_W (SPAN_W)
  ) u_scale_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scale_start),
    .offset_i   (off_x),
    .span_i     (span_x),
    .size_i     (width_q),
    .done_o     (done_x),
    .pixel_o    (scaled_x),
    .in_range_o (ok_x)
  );

  ifs_scale #(
    .OFF_W  (OFF_W),
    .SPAN_W (SPAN_W)
  ) u_scale_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scale_start),
    .offset_i   (off_y),
    .span_i     (span_y),
    .size_i     (height_q),
    .done_o     (done_y),
    .pixel_o    (scaled_y),
    .in_range_o (ok_y)
  );

  // both axes run the same fixed schedule and finish together
  assign scale_done = done_x & done_y;
  assign out_free   = ~m_valid_q | m_axis_tready;

  // sequencer
  always_comb begin
    state_d  = state_q;
    load_out = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (map_start) begin
          state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        if (map_done) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (scale_done) begin
          if (out_free) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        // scale results hold until the next start
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    pix_x_d   = pix_x_q;
    pix_y_d   = pix_y_q;
    in_view_d = in_view_q;
    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (load_out) begin
      m_valid_d = 1'b1;
      pix_x_d   = scaled_x;
      pix_y_d   = scaled_y;
      in_view_d = ok_x & ok_y;
    end
  end

  // configuration registers
  always_comb begin
    preset_d = preset_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_xfer) begin
      case (cfg_index_i)
        REG_PRESET: preset_d = cfg_data_i[ifs_pkg::PRESET_W-1:0];
        REG_WIDTH:  width_d  = cfg_data_i;
        REG_HEIGHT: height_d = cfg_data_i;
        default: begin
          preset_d = preset_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      preset_q  <= ifs_pkg::PRESET_W'(1);
      width_q   <= ifs_pkg::SIZE_W'(640);
      height_q  <= ifs_pkg::SIZE_W'(480);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      preset_q  <= preset_d;
      width_q   <= width_d;
      height_q  <= height_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_x_q   <= pix_x_d;
    pix_y_q   <= pix_y_d;
    in_view_q <= in_view_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {pix_y_q, pix_x_q};
  assign m_axis_tuser  = in_view_q;

endmodule
